### hw/rtl/rcsr_pkg.sv
// Package with shared types, constants and AES helper functions for the rolling-code receiver.
package rcsr_pkg;

   localparam int unsigned AES_ROUNDS = 10;
   localparam logic [7:0] PKT_BYTES = 8'd16;
   localparam logic [31:0] MAX_SKIP_RESET = 32'd50;
   localparam logic [31:0] TIMEOUT_RESET = 32'd3900000;
   localparam int unsigned CSR_ADDR_W = 5;

   localparam logic [CSR_ADDR_W-1:0] REG_KEY_HIGH = 5'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_KEY_LOW = 5'd8;
   localparam logic [CSR_ADDR_W-1:0] REG_MAX_SKIP = 5'd16;
   localparam logic [CSR_ADDR_W-1:0] REG_TIMEOUT = 5'd24;

   localparam logic [1:0] ST_ACCEPTED = 2'd0;
   localparam logic [1:0] ST_REPLAY = 2'd1;
   localparam logic [1:0] ST_DESYNC = 2'd2;
   localparam logic [1:0] ST_HB_LOST = 2'd3;

   typedef logic [127:0] block_type;

   // Last round key of the all-zero key, which is the key after reset.
   localparam block_type LAST_KEY_RESET = 128'hb4ef5bcb_3e92e211_23e951cf_6f8f188e;

   // Control carried down the cell chain next to the data.
   typedef struct packed {
      logic valid;
      logic is_tick;
      logic len_ok;
   } ctl_type;

   typedef struct packed {
      logic [1:0] status;
      logic [31:0] code_word;
      logic [7:0] event_code;
      logic [31:0] tilt_x_bits;
      logic [31:0] tilt_y_bits;
   } rsp_type;

   typedef struct packed {
      logic req_type;
      logic [63:0] block_high;
      logic [63:0] block_low;
      logic [7:0] packet_length;
   } req_type_type;

   function automatic logic [7:0] xtime(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] r;
      logic [7:0] x;
      r = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) r = r ^ x;
         x = xtime(x);
      end
      return r;
   endfunction

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   localparam logic [7:0] INV_SBOX [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
   };

   // Byte i of a 128-bit block, byte 0 in the top bits.
   function automatic logic [7:0] byte_of(input block_type b, input int i);
      return b[127-8*i -: 8];
   endfunction

   localparam logic [7:0] RCON [11] = '{
      8'h8d,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   // Next round key of the forward schedule; rcon for the round being made.
   function automatic block_type key_next(input block_type k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
   endfunction

   // Previous round key, given round key r and the rcon used to make it.
   function automatic block_type key_prev(input block_type k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, p0, p1, p2, p3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      p3 = w3 ^ w2;
      p2 = w2 ^ w1;
      p1 = w1 ^ w0;
      t = {SBOX[p3[23:16]] ^ rc, SBOX[p3[15:8]], SBOX[p3[7:0]], SBOX[p3[31:24]]};
      p0 = w0 ^ t;
      return {p0, p1, p2, p3};
   endfunction

   function automatic block_type inv_shift_sub(input block_type s);
      block_type t;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127-8*(4*c+r) -: 8] = INV_SBOX[byte_of(s, 4*((c+4-r)%4)+r)];
         end
      end
      return t;
   endfunction

   function automatic block_type inv_mix(input block_type s);
      block_type t;
      logic [7:0] a0, a1, a2, a3;
      for (int c = 0; c < 4; c++) begin
         a0 = byte_of(s, 4*c);
         a1 = byte_of(s, 4*c+1);
         a2 = byte_of(s, 4*c+2);
         a3 = byte_of(s, 4*c+3);
         t[127-8*(4*c) -: 8] = gf_mul(a0, 8'd14) ^ gf_mul(a1, 8'd11) ^ gf_mul(a2, 8'd13)
            ^ gf_mul(a3, 8'd9);
         t[127-8*(4*c+1) -: 8] = gf_mul(a0, 8'd9) ^ gf_mul(a1, 8'd14) ^ gf_mul(a2, 8'd11)
            ^ gf_mul(a3, 8'd13);
         t[127-8*(4*c+2) -: 8] = gf_mul(a0, 8'd13) ^ gf_mul(a1, 8'd9) ^ gf_mul(a2, 8'd14)
            ^ gf_mul(a3, 8'd11);
         t[127-8*(4*c+3) -: 8] = gf_mul(a0, 8'd11) ^ gf_mul(a1, 8'd13) ^ gf_mul(a2, 8'd9)
            ^ gf_mul(a3, 8'd14);
      end
      return t;
   endfunction

endpackage

### hw/rtl/rcsr_if.sv
// Valid/ready channel interface carrying one payload beat.
interface rcsr_if #(
   parameter type payload_type = logic
) (
   input logic clock
);
   logic valid;
   logic ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### hw/rtl/rcsr_key_sched.sv
// Key schedule: derives the last round key from the configured key whenever the key changes.
module rcsr_key_sched
   import rcsr_pkg::*;
(
   input logic clock,
   input logic reset,
   input block_type key,
   output block_type last_key
);
   // The user changes the key only while idle; the block itself does not enforce
   // this. Each change restarts a ten-step registered walk, one round key per cycle.
   // Reset loads the result for the all-zero key directly.
   block_type walk_ff, walk_in;
   block_type last_ff, last_in;
   logic [3:0] step_ff, step_in;
   block_type seen_ff;

   always_comb begin
      walk_in = walk_ff;
      step_in = step_ff;
      last_in = last_ff;
      if (seen_ff != key) begin
         walk_in = key;
         step_in = 4'd1;
      end else if (step_ff != 4'd0) begin
         walk_in = key_next(walk_ff, RCON[step_ff]);
         if (step_ff == 4'(AES_ROUNDS)) begin
            step_in = 4'd0;
            last_in = key_next(walk_ff, RCON[step_ff]);
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
         walk_ff <= '0;
         step_ff <= 4'd0;
         last_ff <= LAST_KEY_RESET;
      end else begin
         seen_ff <= key;
         walk_ff <= walk_in;
         step_ff <= step_in;
         last_ff <= last_in;
      end
   end

   assign last_key = last_ff;
endmodule

### hw/rtl/rcsr_round_cell.sv
// One inverse AES round cell: holds a state and round key, passes both on each cycle that advance is high.
module rcsr_round_cell
   import rcsr_pkg::*;
#(
   parameter int unsigned ROUND = 9
) (
   input logic clock,
   input logic reset,
   input logic advance,
   input ctl_type ctl_i,
   input block_type state_i,
   input block_type rkey_i,
   output ctl_type ctl_o,
   output block_type state_o,
   output block_type rkey_o
);
   ctl_type ctl_ff;
   block_type state_ff, state_in;
   block_type rkey_ff, rkey_in;

   // Round key r comes from key r+1 and the rcon that produced it.
   always_comb begin
      rkey_in = key_prev(rkey_i, RCON[ROUND+1]);
      state_in = inv_shift_sub(state_i) ^ rkey_in;
      if (ROUND != 0) state_in = inv_mix(state_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_i;
      end
      if (advance) begin
         state_ff <= state_in;
         rkey_ff <= rkey_in;
      end
   end

   assign ctl_o = ctl_ff;
   assign state_o = state_ff;
   assign rkey_o = rkey_ff;
endmodule

### hw/rtl/rcsr_check.sv
// Rolling-code and watchdog check at the end of the chain, with output register.
module rcsr_check
   import rcsr_pkg::*;
(
   input logic clock,
   input logic reset,
   input ctl_type ctl_i,
   input block_type plain_i,
   input logic [31:0] max_skip,
   input logic [31:0] timeout_ticks,
   input logic out_ready,
   output logic advance,
   output logic out_valid,
   output rsp_type out_data
);
   logic [31:0] last_code_ff, last_code_in;
   logic [31:0] ticks_ff, ticks_in;
   logic valid_ff, valid_in;
   rsp_type data_ff, data_in;
   logic take;
   logic [31:0] code, diff, tick_sat;

   assign advance = !valid_ff || out_ready;
   assign take = ctl_i.valid && advance;

   always_comb begin
      code = {plain_i[103:96], plain_i[111:104], plain_i[119:112], plain_i[127:120]};
      diff = code - last_code_ff;
      tick_sat = (ticks_ff == '1) ? ticks_ff : ticks_ff + 32'd1;
      last_code_in = last_code_ff;
      ticks_in = ticks_ff;
      valid_in = valid_ff && !out_ready;
      data_in = data_ff;
      if (take) begin
         if (ctl_i.is_tick) begin
            if (tick_sat > timeout_ticks) begin
               ticks_in = '0;
               valid_in = 1'b1;
               data_in = '{status: ST_HB_LOST, default: '0};
            end else begin
               ticks_in = tick_sat;
            end
         end else if (ctl_i.len_ok) begin
            valid_in = 1'b1;
            data_in.code_word = code;
            data_in.event_code = plain_i[95:88];
            data_in.tilt_x_bits = {plain_i[39:32], plain_i[47:40], plain_i[55:48],
               plain_i[63:56]};
            data_in.tilt_y_bits = {plain_i[7:0], plain_i[15:8], plain_i[23:16],
               plain_i[31:24]};
            if (last_code_ff != '0 && code <= last_code_ff) begin
               data_in.status = ST_REPLAY;
            end else if (last_code_ff != '0 && diff > max_skip) begin
               data_in.status = ST_DESYNC;
            end else begin
               data_in.status = ST_ACCEPTED;
               last_code_in = code;
               ticks_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_code_ff <= '0;
         ticks_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         last_code_ff <= last_code_in;
         ticks_ff <= ticks_in;
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;
endmodule

### hw/rtl/rolling_code_secure_receiver.sv
// Top level of the rolling-code secure receiver.
// Each beat passes a chain of ten inverse-round cells and then the check stage's
// output register; one beat is taken every cycle while the result side keeps
// up, so throughput is one item per clock. A key write is absorbed by the key
// schedule through its registered walk; configure while no beats are in flight. Tick
// beats travel the same chain so results keep the order of arrival. The
// configuration port takes 64-bit registers at byte addresses 0, 8, 16 and 24.
module rolling_code_secure_receiver
   import rcsr_pkg::*;
(
   input logic clock,
   input logic reset,
   rcsr_if.sink req,
   rcsr_if.source rsp,
   input logic csr_psel,
   input logic csr_penable,
   input logic csr_pwrite,
   input logic [CSR_ADDR_W-1:0] csr_paddr,
   input logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic csr_pready
);
   logic [63:0] key_high_ff, key_low_ff;
   logic [31:0] max_skip_ff, timeout_ff;
   block_type last_key;
   logic advance;
   logic out_valid;
   rsp_type out_data;
   req_type_type rq;

   ctl_type ctl_c [AES_ROUNDS+1];
   block_type state_c [AES_ROUNDS+1];
   block_type rkey_c [AES_ROUNDS+1];

   assign csr_pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff <= '0;
         max_skip_ff <= MAX_SKIP_RESET;
         timeout_ff <= TIMEOUT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_paddr)
            REG_KEY_HIGH: key_high_ff <= csr_pwdata;
            REG_KEY_LOW: key_low_ff <= csr_pwdata;
            REG_MAX_SKIP: max_skip_ff <= csr_pwdata[31:0];
            REG_TIMEOUT: timeout_ff <= csr_pwdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr)
         REG_KEY_HIGH: csr_prdata = key_high_ff;
         REG_KEY_LOW: csr_prdata = key_low_ff;
         REG_MAX_SKIP: csr_prdata = {32'd0, max_skip_ff};
         REG_TIMEOUT: csr_prdata = {32'd0, timeout_ff};
         default: csr_prdata = '0;
      endcase
   end

   rcsr_key_sched u_key (
      .clock(clock),
      .reset(reset),
      .key({key_high_ff, key_low_ff}),
      .last_key(last_key)
   );

   assign rq = req.payload;
   assign req.ready = advance;
   assign ctl_c[0] = '{valid: req.valid, is_tick: rq.req_type,
      len_ok: (rq.packet_length == PKT_BYTES)};
   assign state_c[0] = {rq.block_high, rq.block_low} ^ last_key;
   assign rkey_c[0] = last_key;

   for (genvar g = 0; g < AES_ROUNDS; g++) begin : g_cell
      rcsr_round_cell #(.ROUND(AES_ROUNDS - 1 - g)) u_cell (
         .clock(clock),
         .reset(reset),
         .advance(advance),
         .ctl_i(ctl_c[g]),
         .state_i(state_c[g]),
         .rkey_i(rkey_c[g]),
         .ctl_o(ctl_c[g+1]),
         .state_o(state_c[g+1]),
         .rkey_o(rkey_c[g+1])
      );
   end

   rcsr_check u_check (
      .clock(clock),
      .reset(reset),
      .ctl_i(ctl_c[AES_ROUNDS]),
      .plain_i(state_c[AES_ROUNDS]),
      .max_skip(max_skip_ff),
      .timeout_ticks(timeout_ff),
      .out_ready(rsp.ready),
      .advance(advance),
      .out_valid(out_valid),
      .out_data(out_data)
   );

   assign rsp.valid = out_valid;
   assign rsp.payload = out_data;
endmodule
